// ----- src/ctc_pkg.sv -----
// Shared constants for the columnar transposition cipher block.
// No dependencies; used by the top level and its port checker.
package ctc_pkg;

  localparam logic [7:0] SPACE_BYTE = 8'h20;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_FETCH  = 1'b1;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_KEY_LENGTH = 3'd1;
  localparam logic [2:0] REG_KEY_A      = 3'd2;
  localparam logic [2:0] REG_KEY_B      = 3'd3;
  localparam logic [2:0] REG_KEY_C      = 3'd4;
  localparam logic [2:0] REG_KEY_D      = 3'd5;
  localparam logic [2:0] REG_PAD_BYTE   = 3'd6;

  localparam logic [5:0]  KEY_LENGTH_RESET = 6'd1;
  localparam logic [7:0]  PAD_BYTE_RESET   = 8'd88;

endpackage

// ----- src/columnar_transposition_cipher.sv -----
// Columnar transposition engine: an append beat is taken in its accept cycle. A fetch runs the
// shared restoring divider twice (NW = clog2(MAX_TEXT + MAX_COLUMNS) bits) and a rank scan of the
// shared compare bank (one round when decrypting, else one per column up to the key-order column
// found), then S_ADDR, S_IDX, S_READ, S_EMIT. An empty-buffer fetch goes from S_CHECK to S_EMIT
// after the first division. Input is ready again in the cycle after the result is loaded, later
// while an earlier result is stalled. Synchronous active-high reset empties buffer, loads defaults.
module columnar_transposition_cipher #(
  parameter int MAX_TEXT    = 1024,
  parameter int MAX_COLUMNS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] command
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // [0] status
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int NW  = $clog2(MAX_TEXT + MAX_COLUMNS);
  localparam int CW  = $clog2(MAX_TEXT + 1);
  localparam int AW  = $clog2(MAX_TEXT);
  localparam int KW  = $clog2(MAX_COLUMNS + 1);
  localparam int IW  = $clog2(MAX_COLUMNS);
  localparam int DCW = $clog2(NW);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV1, S_TOTAL, S_CHECK, S_DIV2, S_CMP, S_CNT,
    S_ADDR, S_IDX, S_READ, S_EMIT
  } state_t;

  // configuration
  logic        mode;
  logic [5:0]  key_length;
  logic [63:0] key_a, key_b, key_c, key_d;
  logic [7:0]  pad_byte;
  logic [255:0] key_flat;

  // buffer and sequencer
  state_t            state;
  logic [7:0]        text_store [MAX_TEXT];
  logic [CW-1:0]     text_count;
  logic [NW-1:0]     out_position;
  logic [KW-1:0]     cols;
  logic [NW-1:0]     rows;
  logic [NW-1:0]     total;
  logic [NW-1:0]     div_rem, div_quo, div_den;
  logic [DCW-1:0]    div_cnt;
  logic [IW-1:0]     cand;
  logic [IW-1:0]     rank;
  logic [MAX_COLUMNS-1:0] less;
  logic [NW-1:0]     prod;
  logic [NW-1:0]     idx;
  logic [7:0]        mem_q;
  logic              hit;
  logic              empty;

  logic              cfg_wr;
  logic [KW-1:0]     cols_next;
  logic [NW:0]       trial;
  logic              ge;
  logic [IW-1:0]     cand_sel;
  logic [7:0]        cand_key;
  logic [MAX_COLUMNS-1:0] less_next;
  logic [IW-1:0]     cnt;
  logic [NW-1:0]     mul_a, mul_b;
  logic [2*NW-1:0]   mul_p;
  logic              append_ok;
  logic              is_last;

  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign s_axis_tready = (state == S_IDLE);
  assign key_flat      = {key_d, key_c, key_b, key_a};

  always_comb begin
    if (key_length == 6'd0) begin
      cols_next = KW'(1);
    end else if (key_length > 6'(MAX_COLUMNS)) begin
      cols_next = KW'(MAX_COLUMNS);
    end else begin
      cols_next = KW'(key_length);
    end
  end

  // one restoring divider step
  assign trial = {div_rem, div_quo[NW-1]};
  assign ge    = (trial >= {1'b0, div_den});

  // rank compare bank: columns sorting ahead of the candidate
  assign cand_sel = (mode == ctc_pkg::MODE_DECRYPT) ? div_rem[IW-1:0] : cand;
  assign cand_key = key_flat[8*cand_sel +: 8];

  always_comb begin
    for (int j = 0; j < MAX_COLUMNS; j++) begin
      less_next[j] = (KW'(j) < cols) &&
                     ((key_flat[8*j +: 8] < cand_key) ||
                      ((key_flat[8*j +: 8] == cand_key) && (IW'(j) < cand_sel)));
    end
  end

  assign cnt = IW'($countones(less));

  // shared multiplier
  always_comb begin
    mul_a = rows;
    mul_b = NW'(cols);
    case (state)
      S_TOTAL: begin
        mul_a = div_quo;
        mul_b = NW'(cols);
      end
      S_ADDR: begin
        if (mode == ctc_pkg::MODE_DECRYPT) begin
          mul_a = NW'(rank);
          mul_b = rows;
        end else begin
          mul_a = div_rem;
          mul_b = NW'(cols);
        end
      end
      default: begin
        mul_a = rows;
        mul_b = NW'(cols);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign append_ok = !((mode == ctc_pkg::MODE_ENCRYPT) && (s_axis_tdata == ctc_pkg::SPACE_BYTE))
                     && (out_position == '0) && (text_count < CW'(MAX_TEXT));
  assign is_last   = ((out_position + NW'(1)) >= total);

  // register port
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= ctc_pkg::MODE_ENCRYPT;
      key_length <= ctc_pkg::KEY_LENGTH_RESET;
      key_a      <= '0;
      key_b      <= '0;
      key_c      <= '0;
      key_d      <= '0;
      pad_byte   <= ctc_pkg::PAD_BYTE_RESET;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        ctc_pkg::REG_MODE:       mode       <= pwdata[0];
        ctc_pkg::REG_KEY_LENGTH: key_length <= pwdata[5:0];
        ctc_pkg::REG_KEY_A:      key_a      <= pwdata;
        ctc_pkg::REG_KEY_B:      key_b      <= pwdata;
        ctc_pkg::REG_KEY_C:      key_c      <= pwdata;
        ctc_pkg::REG_KEY_D:      key_d      <= pwdata;
        ctc_pkg::REG_PAD_BYTE:   pad_byte   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      ctc_pkg::REG_MODE:       prdata = {63'd0, mode};
      ctc_pkg::REG_KEY_LENGTH: prdata = {58'd0, key_length};
      ctc_pkg::REG_KEY_A:      prdata = key_a;
      ctc_pkg::REG_KEY_B:      prdata = key_b;
      ctc_pkg::REG_KEY_C:      prdata = key_c;
      ctc_pkg::REG_KEY_D:      prdata = key_d;
      ctc_pkg::REG_PAD_BYTE:   prdata = {56'd0, pad_byte};
      default:                 prdata = '0;
    endcase
  end

  // message buffer
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid && s_axis_tuser == ctc_pkg::CMD_APPEND && append_ok) begin
      text_store[text_count[AW-1:0]] <= s_axis_tdata;
    end
    if (state == S_READ) begin
      mem_q <= text_store[idx[AW-1:0]];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      text_count    <= '0;
      out_position  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // in S_EMIT the output register is reloaded or held below
      if (m_axis_tvalid && m_axis_tready && state != S_EMIT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser == ctc_pkg::CMD_FETCH) begin
              // rows = ceil(count / cols)
              cols    <= cols_next;
              div_rem <= '0;
              div_quo <= NW'(text_count) + NW'(cols_next) - NW'(1);
              div_den <= NW'(cols_next);
              div_cnt <= DCW'(NW - 1);
              state   <= S_DIV1;
            end else if (append_ok) begin
              text_count <= text_count + CW'(1);
            end
          end
        end
        S_DIV1, S_DIV2: begin
          div_rem <= ge ? NW'(trial - {1'b0, div_den}) : trial[NW-1:0];
          div_quo <= {div_quo[NW-2:0], ge};
          div_cnt <= div_cnt - DCW'(1);
          if (div_cnt == '0) begin
            state <= (state == S_DIV1) ? S_TOTAL : S_CMP;
          end
        end
        S_TOTAL: begin
          rows  <= div_quo;
          total <= mul_p[NW-1:0];
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (text_count == '0 || out_position >= total) begin
            empty <= 1'b1;
            state <= S_EMIT;
          end else begin
            empty   <= 1'b0;
            cand    <= '0;
            div_rem <= '0;
            div_quo <= out_position;
            div_den <= (mode == ctc_pkg::MODE_DECRYPT) ? NW'(cols) : rows;
            div_cnt <= DCW'(NW - 1);
            state   <= S_DIV2;
          end
        end
        S_CMP: begin
          less  <= less_next;
          state <= S_CNT;
        end
        S_CNT: begin
          if (mode == ctc_pkg::MODE_DECRYPT) begin
            rank  <= cnt;
            state <= S_ADDR;
          end else if (NW'(cnt) == div_quo || cand == IW'(cols - KW'(1))) begin
            state <= S_ADDR;
          end else begin
            cand  <= cand + IW'(1);
            state <= S_CMP;
          end
        end
        S_ADDR: begin
          prod  <= mul_p[NW-1:0];
          state <= S_IDX;
        end
        S_IDX: begin
          idx   <= prod + ((mode == ctc_pkg::MODE_DECRYPT) ? div_quo : NW'(cand));
          state <= S_READ;
        end
        S_READ: begin
          hit   <= (idx < NW'(text_count));
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            if (empty) begin
              m_axis_tdata <= 8'd0;
              m_axis_tlast <= 1'b0;
              m_axis_tuser <= ctc_pkg::STATUS_EMPTY;
              text_count   <= '0;
              out_position <= '0;
            end else begin
              m_axis_tdata <= hit ? mem_q : pad_byte;
              m_axis_tlast <= is_last;
              m_axis_tuser <= ctc_pkg::STATUS_OK;
              if (is_last) begin
                text_count   <= '0;
                out_position <= '0;
              end else begin
                out_position <= out_position + NW'(1);
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/ctc_checker.sv -----
// Port-level checks for the columnar transposition cipher block.
// Depends on ctc_pkg; bound to the top level below.
module ctc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output payload changed while stalled");

  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ctc_pkg::STATUS_EMPTY |->
      m_axis_tdata == 8'd0 && !m_axis_tlast)
    else $error("empty-buffer beat carries data or last");

  a_fetch_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ctc_pkg::CMD_FETCH |=> !s_axis_tready)
    else $error("fetch did not start the sequencer");

  a_append_fast: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ctc_pkg::CMD_APPEND |=> s_axis_tready)
    else $error("append stalled the input");

endmodule

bind columnar_transposition_cipher ctc_checker u_ctc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
